// ===== rtl/ordered_list_insert_delete_find_defines.svh =====
// Assertion macros shared by the checker.
`ifndef ORDERED_LIST_INSERT_DELETE_FIND_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_FIND_DEFINES_SVH

// Same-cycle implication, inactive while reset is applied.
`define OLID_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Next-cycle implication, also active during reset.
`define OLID_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

// ===== rtl/olid_pkg.sv =====
package olid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int Q_DEPTH      = 2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    typedef enum logic [1:0] {
        OP_INS,
        OP_DEL,
        OP_FIND,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_PUT,
        ST_DEL,
        ST_FIND
    } t_bstate;

    typedef struct packed {
        logic [1:0]          kind;
        logic [6:0]          position;
        logic signed [31:0]  value;
    } t_in;

    typedef struct packed {
        logic                ok;
        logic signed [31:0]  removed_value;
        logic [6:0]          found_position;
        logic [6:0]          list_length;
    } t_out;

    typedef struct packed {
        t_op                 op;
        logic [6:0]          position;
        logic [31:0]         value;
    } t_cmd;

endpackage

// ===== rtl/olid_front.sv =====
module olid_front (
    input  logic               start,
    input  olid_pkg::t_in      i_item,
    input  logic               i_full,
    output logic               busy,
    output logic               o_push,
    output olid_pkg::t_cmd     o_cmd
);

    olid_pkg::t_op op;

    always_comb begin
        case (i_item.kind)
            olid_pkg::KIND_INSERT: op = olid_pkg::OP_INS;
            olid_pkg::KIND_DELETE: op = olid_pkg::OP_DEL;
            olid_pkg::KIND_FIND:   op = olid_pkg::OP_FIND;
            default:               op = olid_pkg::OP_NOP;
        endcase
    end

    assign busy           = i_full;
    assign o_push         = start && !i_full;
    assign o_cmd.op       = op;
    assign o_cmd.position = i_item.position;
    assign o_cmd.value    = i_item.value;

endmodule

// ===== rtl/olid_queue.sv =====
module olid_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  olid_pkg::t_cmd    i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output olid_pkg::t_cmd    o_data
);

    localparam int PW = (olid_pkg::Q_DEPTH > 1) ? $clog2(olid_pkg::Q_DEPTH) : 1;
    localparam int NW = $clog2(olid_pkg::Q_DEPTH + 1);

    olid_pkg::t_cmd  r_slot [olid_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [NW-1:0]   r_cnt;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;
    logic [NW-1:0]   n_cnt;

    assign o_full  = (r_cnt == NW'(olid_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(olid_pkg::Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(olid_pkg::Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/olid_back.sv =====
module olid_back #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  olid_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_done,
    output olid_pkg::t_out    o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    logic [31:0]         mem [CAPACITY];
    logic [31:0]         r_rd;

    olid_pkg::t_bstate   r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_rdi, n_rdi;
    logic [AW-1:0]       r_wa, n_wa;
    logic                r_wv, n_wv;
    logic                r_cap, n_cap;
    logic [31:0]         r_removed, n_removed;
    logic [AW-1:0]       r_pm1, n_pm1;
    logic [31:0]         r_val, n_val;
    logic                r_done, n_done;
    olid_pkg::t_out      r_res, n_res;

    logic [AW-1:0]       ra;
    logic                we;
    logic [AW-1:0]       wa;
    logic [31:0]         wd;
    logic [XW-1:0]       xpos;
    logic [XW-1:0]       xcnt;
    logic [CW-1:0]       next_rdi;
    logic [31:0]         rem_now;

    assign o_done   = r_done;
    assign o_result = r_res;

    assign xpos     = XW'(i_cmd.position);
    assign xcnt     = XW'(r_count);
    assign next_rdi = CW'(r_rdi) + CW'(1);
    assign rem_now  = r_cap ? r_rd : r_removed;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rdi     = r_rdi;
        n_wa      = r_wa;
        n_wv      = 1'b0;
        n_cap     = r_cap;
        n_removed = r_removed;
        n_pm1     = r_pm1;
        n_val     = r_val;
        n_done    = 1'b0;
        n_res     = r_res;
        o_pop     = 1'b0;
        ra        = '0;
        we        = r_wv;
        wa        = r_wa;
        wd        = r_rd;

        case (r_state)
            olid_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_res.ok             = 1'b0;
                    n_res.removed_value  = '0;
                    n_res.found_position = '0;
                    n_res.list_length    = 7'(r_count);
                    n_val = i_cmd.value;
                    n_pm1 = AW'(xpos - XW'(1));
                    case (i_cmd.op)
                        olid_pkg::OP_INS: begin
                            if (xpos == '0 || xpos > xcnt + XW'(1)
                                    || r_count == CW'(CAPACITY)) begin
                                n_done = 1'b1;
                            end else if (xpos - XW'(1) == xcnt) begin
                                we      = 1'b1;
                                wa      = AW'(r_count);
                                wd      = i_cmd.value;
                                n_count = r_count + CW'(1);
                                n_done  = 1'b1;
                                n_res.ok          = 1'b1;
                                n_res.list_length = 7'(r_count + CW'(1));
                            end else begin
                                ra      = AW'(r_count - CW'(1));
                                n_rdi   = AW'(r_count - CW'(1));
                                n_wa    = AW'(r_count);
                                n_wv    = 1'b1;
                                n_state = olid_pkg::ST_INS;
                            end
                        end
                        olid_pkg::OP_DEL: begin
                            if (xpos == '0 || xpos > xcnt) begin
                                n_done = 1'b1;
                            end else begin
                                ra      = AW'(xpos - XW'(1));
                                n_rdi   = AW'(xpos - XW'(1));
                                n_cap   = 1'b1;
                                n_state = olid_pkg::ST_DEL;
                            end
                        end
                        olid_pkg::OP_FIND: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                ra      = '0;
                                n_rdi   = '0;
                                n_state = olid_pkg::ST_FIND;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            olid_pkg::ST_INS: begin
                if (r_rdi != r_pm1) begin
                    ra    = r_rdi - AW'(1);
                    n_rdi = r_rdi - AW'(1);
                    n_wa  = r_rdi;
                    n_wv  = 1'b1;
                end else begin
                    n_state = olid_pkg::ST_INS_PUT;
                end
            end
            olid_pkg::ST_INS_PUT: begin
                we      = 1'b1;
                wa      = r_pm1;
                wd      = r_val;
                n_count = r_count + CW'(1);
                n_done  = 1'b1;
                n_res.ok          = 1'b1;
                n_res.list_length = 7'(r_count + CW'(1));
                n_state = olid_pkg::ST_IDLE;
            end
            olid_pkg::ST_DEL: begin
                n_cap     = 1'b0;
                n_removed = rem_now;
                if (next_rdi < r_count) begin
                    ra    = AW'(next_rdi);
                    n_rdi = AW'(next_rdi);
                    n_wa  = r_rdi;
                    n_wv  = 1'b1;
                end else begin
                    n_count = r_count - CW'(1);
                    n_done  = 1'b1;
                    n_res.ok            = 1'b1;
                    n_res.removed_value = rem_now;
                    n_res.list_length   = 7'(r_count - CW'(1));
                    n_state = olid_pkg::ST_IDLE;
                end
            end
            olid_pkg::ST_FIND: begin
                if (r_rd == r_val) begin
                    n_done  = 1'b1;
                    n_res.ok             = 1'b1;
                    n_res.found_position = 7'(next_rdi);
                    n_state = olid_pkg::ST_IDLE;
                end else if (next_rdi < r_count) begin
                    ra    = AW'(next_rdi);
                    n_rdi = AW'(next_rdi);
                end else begin
                    n_done  = 1'b1;
                    n_state = olid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = olid_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olid_pkg::ST_IDLE;
            r_count <= '0;
            r_wv    <= 1'b0;
            r_cap   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wv    <= n_wv;
            r_cap   <= n_cap;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdi     <= n_rdi;
        r_wa      <= n_wa;
        r_removed <= n_removed;
        r_pm1     <= n_pm1;
        r_val     <= n_val;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

endmodule

// ===== rtl/ordered_list_insert_delete_find.sv =====
// A failed request or an append is finished by the back end as it takes the beat from the queue.
// An insert shifts the elements from the end down to the position up one at a time and then
// writes the value, a delete shifts the later elements down one at a time, and a find scans
// from the first element; the single read port and single write port of the element memory
// set this pace. A request starts once the last is done; up to two beats wait in the queue.
// Synchronous active-low reset clears the length, queue and control; memory is not cleared.
module ordered_list_insert_delete_find #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  olid_pkg::t_in     i_item,
    output logic              busy,
    output logic              o_done,
    output olid_pkg::t_out    o_result
);

    logic            push;
    logic            full;
    logic            q_valid;
    logic            pop;
    olid_pkg::t_cmd  cmd_in;
    olid_pkg::t_cmd  cmd_out;

    olid_front u_front (
        .start   (start),
        .i_item  (i_item),
        .i_full  (full),
        .busy    (busy),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    olid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (cmd_out)
    );

    olid_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (cmd_out),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== rtl/olid_checker.sv =====
`include "ordered_list_insert_delete_find_defines.svh"

module olid_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_busy,
    input  logic              i_done,
    input  olid_pkg::t_out    i_result
);

    logic        no_extras;
    logic [6:0]  r_len_prev;
    logic [6:0]  len_delta;

    assign no_extras = (i_result.removed_value == '0) && (i_result.found_position == '0);
    assign len_delta = i_result.list_length - r_len_prev;

    always_ff @(posedge i_clk) begin
        r_len_prev <= i_result.list_length;
    end

    `OLID_IMPLY(a_fail_clean, i_done && !i_result.ok, no_extras)
    `OLID_IMPLY(a_found_ok, i_done && i_result.found_position != 0, i_result.ok)
    `OLID_IMPLY(a_len_step, i_done && $past(i_done), len_delta <= 7'd1 || len_delta == 7'h7f)
    `OLID_NEXT(a_rst_quiet, !i_rst_n, !i_busy && !i_done)

endmodule

bind ordered_list_insert_delete_find olid_checker u_olid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_busy   (busy),
    .i_done   (o_done),
    .i_result (o_result)
);
